>>> hdl/first_fit_segment_allocator_top_defines.svh
// Assertion helpers for the segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FFSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FFSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned ADDR_W = 23;
  localparam int unsigned OWN_W = 16;
  localparam logic [ADDR_W-1:0] CAP_RESET = ADDR_W'(3 * 1024 * 1024);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_FND  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [OWN_W-1:0]  owner_id;
    logic [ADDR_W-1:0] request_size;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OWN_W-1:0]  seg_owner;
    logic [ADDR_W-1:0] seg_start;
    logic              last;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // reset scan index
    logic scan_inc;   // advance scan index
    logic insert;     // insert at pos (one step of shifting handled as bulk shift)
    logic remove;     // remove at scan index
    logic bub_clr;    // restart a sort pass
    logic bub_step;   // compare/swap at scan index
    logic pack_step;  // relocate entry at scan index
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;   // scan index at last pair / entry
    logic empty;
    logic alloc_early; // admission decided: reject or place
    logic own_hit;
    logic swapped;
    logic out_last;   // result register holds the final beat of the item
  } dp_sts_t;
endpackage
`default_nettype wire

>>> hdl/ffsa_if.sv
`default_nettype none
interface ffsa_in_if import ffsa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffsa_out_if import ffsa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/first_fit_segment_allocator_top.sv
// First-fit segment allocator: one beat in (allocate, free by owner, compact),
// one result beat per allocate or free, one per segment for compact (none if
// the table is empty). Items are processed one at a time. Allocate and free
// scan the table one entry per cycle; compact runs a bubble sort that stops
// after a pass with no swap and then emits the segments one at a time. The
// capacity register is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block itself has no check for this.
`default_nettype none
module first_fit_segment_allocator_top import ffsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ffsa_in_if.sink                in_ch,
  ffsa_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_beat_t res;

  ffsa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_op (in_ch.data.op), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .sts, .cmd
  );

  ffsa_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .req (in_ch.data), .cmd, .sts, .res
  );

  assign out_ch.data = res;
endmodule
`default_nettype wire

>>> hdl/ffsa_datapath.sv
`default_nettype none
module ffsa_datapath import ffsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire in_beat_t          req,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  output out_beat_t              res
);
  logic [OWN_W-1:0]  own_r   [SLOTS];
  logic [ADDR_W-1:0] start_r [SLOTS];
  logic [ADDR_W-1:0] size_r  [SLOTS];
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] used_r, cap_r;
  in_beat_t          req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  lim_r;     // sort pass length
  logic              swp_r;
  logic [ADDR_W:0]   addr_r;    // pack address
  logic [CNT_W-1:0]  pos_r;
  logic [ADDR_W-1:0] place_r;
  logic [1:0]        rstat_r;
  logic              placed_r;

  logic [ADDR_W:0]   end_i, nxt_i, gap;
  logic [ADDR_W:0]   tot;
  logic [ADDR_W:0]   fin;
  logic [CNT_W-1:0]  idx_ext;
  logic [IDX_W-1:0]  idx_p1;

  assign idx_ext = CNT_W'(idx_r);
  assign idx_p1  = idx_r + 1'b1;
  assign end_i   = {1'b0, start_r[idx_r]} + {1'b0, size_r[idx_r]};
  assign nxt_i   = {1'b0, start_r[idx_p1]};
  assign gap     = nxt_i - end_i;
  assign tot     = {1'b0, used_r} + {1'b0, req_r.request_size};
  assign fin     = {1'b0, place_r} + {1'b0, req_r.request_size};

  always_comb begin
    sts.empty     = (cnt_r == '0);
    sts.own_hit   = (own_r[idx_r] == req_r.owner_id);
    sts.swapped   = swp_r;
    sts.scan_end  = (idx_ext + 1'b1 >= cnt_r) || (idx_ext + 1'b1 >= lim_r);
    sts.alloc_early = placed_r;
    sts.out_last  = res.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      used_r <= '0;
      cap_r  <= CAP_RESET;
      placed_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.load) begin
        req_r <= req;
        idx_r <= '0;
        lim_r <= cnt_r;
        addr_r <= '0;
        placed_r <= 1'b0;
        swp_r <= 1'b0;
        rstat_r <= ST_OK;
        res.seg_owner <= req.owner_id;
        res.seg_start <= '0;
        res.status <= ST_OK;
        res.last <= 1'b1;
      end
      if (cmd.scan_clr) begin
        idx_r <= '0;
        placed_r <= 1'b0;
        // admission checks for allocate
        if (req_r.op == OP_ALLOC) begin
          if (tot > {1'b0, cap_r}) begin
            rstat_r <= ST_NO_SPACE; placed_r <= 1'b1;
          end else if (cnt_r >= CNT_W'(SLOTS)) begin
            rstat_r <= ST_FULL; placed_r <= 1'b1;
          end else if (cnt_r == '0 || req_r.request_size <= start_r[0]) begin
            rstat_r <= ST_OK; placed_r <= 1'b1; pos_r <= '0; place_r <= '0;
          end else begin
            rstat_r <= ST_OK; pos_r <= cnt_r;
            place_r <= start_r[IDX_W'(cnt_r - 1'b1)] + size_r[IDX_W'(cnt_r - 1'b1)];
            if ({1'b0, start_r[IDX_W'(cnt_r - 1'b1)]} + {1'b0, size_r[IDX_W'(cnt_r - 1'b1)]}
                > {1'b0, {ADDR_W{1'b1}}})
              rstat_r <= ST_NO_SPACE;
          end
        end
      end
      if (cmd.scan_inc) begin
        // first-fit pair test at idx, idx+1
        if (req_r.op == OP_ALLOC && !placed_r && idx_ext + 1'b1 < cnt_r &&
            end_i <= nxt_i && {1'b0, req_r.request_size} <= gap) begin
          placed_r <= 1'b1; rstat_r <= ST_OK;
          pos_r <= idx_ext + 1'b1; place_r <= end_i[ADDR_W-1:0];
        end
        idx_r <= idx_p1;
      end
      if (cmd.insert) begin
        res.status <= rstat_r;
        if (rstat_r == ST_OK && fin > {1'b0, {ADDR_W{1'b1}}}) begin
          res.status <= ST_NO_SPACE;
        end else if (rstat_r == ST_OK) begin
          for (int i = SLOTS - 1; i >= 1; i--) begin
            if (CNT_W'(i) > pos_r && CNT_W'(i) <= cnt_r) begin
              own_r[i] <= own_r[i-1]; start_r[i] <= start_r[i-1]; size_r[i] <= size_r[i-1];
            end
          end
          own_r[IDX_W'(pos_r)]   <= req_r.owner_id;
          start_r[IDX_W'(pos_r)] <= place_r;
          size_r[IDX_W'(pos_r)]  <= req_r.request_size;
          cnt_r <= cnt_r + 1'b1;
          used_r <= tot[ADDR_W-1:0];
          res.seg_start <= place_r;
        end
      end
      if (cmd.remove) begin
        if (idx_ext < cnt_r && sts.own_hit) begin
          for (int i = 0; i < SLOTS - 1; i++) begin
            if (CNT_W'(i) >= idx_ext && CNT_W'(i) + 1'b1 < cnt_r) begin
              own_r[i] <= own_r[i+1]; start_r[i] <= start_r[i+1]; size_r[i] <= size_r[i+1];
            end
          end
          cnt_r <= cnt_r - 1'b1;
          used_r <= (used_r >= size_r[idx_r]) ? used_r - size_r[idx_r] : '0;
          res.seg_start <= start_r[idx_r];
        end else begin
          res.status <= ST_NOT_FND;
        end
      end
      if (cmd.bub_clr) begin
        idx_r <= '0;
        swp_r <= 1'b0;
        if (lim_r != '0) lim_r <= lim_r - 1'b1;
      end
      if (cmd.bub_step) begin
        if (idx_ext + 1'b1 < lim_r && own_r[idx_r] > own_r[idx_p1]) begin
          own_r[idx_r] <= own_r[idx_p1];     own_r[idx_p1] <= own_r[idx_r];
          start_r[idx_r] <= start_r[idx_p1]; start_r[idx_p1] <= start_r[idx_r];
          size_r[idx_r] <= size_r[idx_p1];   size_r[idx_p1] <= size_r[idx_r];
          swp_r <= 1'b1;
        end
        idx_r <= idx_p1;
      end
      if (cmd.pack_step) begin
        start_r[idx_r] <= addr_r[ADDR_W-1:0];
        res.status <= ST_OK;
        res.seg_owner <= own_r[idx_r];
        res.seg_start <= addr_r[ADDR_W-1:0];
        res.last <= (idx_ext + 1'b1 == cnt_r);
        addr_r <= addr_r + {1'b0, size_r[idx_r]};
        idx_r <= idx_p1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl import ffsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic [1:0] in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dp_sts_t   sts,
  output dp_cmd_t        cmd
);
  `include "first_fit_segment_allocator_top_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_INSERT, S_FREE_SCAN, S_SORT_PASS, S_SORT_NEXT,
    S_PACK, S_EMIT, S_PACK_WAIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic [1:0] op_r;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:      cmd.load = in_valid && in_ready;
      // first sort pass runs over the whole table, so no pass restart here
      S_DISPATCH:  cmd.scan_clr = (op_r == OP_ALLOC) || (op_r == OP_FREE);
      S_SCAN:      cmd.scan_inc = !sts.alloc_early && !sts.scan_end;
      S_INSERT:    cmd.insert = 1'b1;
      S_FREE_SCAN: begin
        cmd.remove   = sts.own_hit || sts.scan_end || sts.empty;
        cmd.scan_inc = !(sts.own_hit || sts.scan_end || sts.empty);
      end
      S_SORT_PASS: cmd.bub_step = !sts.scan_end;
      S_SORT_NEXT: cmd.bub_clr = 1'b1;
      S_PACK:      cmd.pack_step = 1'b1;
      S_EMIT, S_PACK_WAIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r <= OP_NONE;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          op_r <= in_op; state_r <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (op_r)
            OP_ALLOC:   state_r <= S_SCAN;
            OP_FREE:    state_r <= S_FREE_SCAN;
            OP_COMPACT: state_r <= S_SORT_PASS;
            default:    state_r <= S_IDLE;
          endcase
        end
        // early or end of pair scan: commit
        S_SCAN: if (sts.alloc_early || sts.scan_end) state_r <= S_INSERT;
        S_INSERT: begin out_valid_r <= 1'b1; state_r <= S_EMIT; end
        S_FREE_SCAN: if (sts.own_hit || sts.scan_end || sts.empty) begin
          out_valid_r <= 1'b1; state_r <= S_EMIT;
        end
        S_SORT_PASS: if (sts.scan_end) state_r <= S_SORT_NEXT;
        // stop sorting after a pass without a swap
        S_SORT_NEXT: state_r <= sts.swapped ? S_SORT_PASS : S_PACK_WAIT;
        S_PACK_WAIT: state_r <= sts.empty ? S_IDLE : S_PACK;
        S_PACK: begin out_valid_r <= 1'b1; state_r <= S_EMIT; end
        S_EMIT: if (out_ready) begin
          // compact returns to pack until the last beat
          state_r <= (op_r == OP_COMPACT && !sts.out_last) ? S_PACK : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FFSA_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE, "ready outside idle")
  `FFSA_ASSERT_NXT(a_load_leaves, in_valid && in_ready, state_r == S_DISPATCH,
                   "accepted beat not dispatched")
  `FFSA_ASSERT_IMP(a_valid_emit, out_valid_r, state_r == S_EMIT, "result outside emit")
  `FFSA_ASSERT_NXT(a_hold, out_valid_r && !out_ready, out_valid_r, "result dropped")
endmodule
`default_nettype wire
